// ===== rtl/core/pds_pkg.sv =====
// Package for the proper divisor sum block: widths and controller states.
// No dependencies; used by pds_div, proper_divisor_sum and tb_top.
`timescale 1ns / 1ps
`default_nettype none
package pds_pkg;

	localparam int VALUE_BITS = 32;
	localparam int IN_BITS    = 32;
	localparam int OUT_BITS   = 35;
	// The input field carries 32 bits, so n never grows past that.
	localparam int N_BITS     = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
	// Candidates run up to floor(sqrt(n)) + 1.
	localparam int D_BITS     = (N_BITS + 1) / 2 + 1;
	localparam int CNT_BITS   = $clog2(N_BITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_DIV,
		ST_CHECK,
		ST_FINISH
	} pds_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/pds_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, N_BITS quotient bits.
// Depends on pds_pkg for N_BITS, D_BITS and CNT_BITS.
`timescale 1ns / 1ps
`default_nettype none
module pds_div import pds_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [N_BITS-1:0] dividend,
	input  wire logic [D_BITS-1:0] divisor,
	output logic                   done,
	output logic [N_BITS-1:0]      quotient,
	output logic [D_BITS-1:0]      remainder
);

	logic                run_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [N_BITS-1:0]   quo_q;
	logic [D_BITS-1:0]   rem_q;
	logic [D_BITS:0]     rem_sh;
	logic [D_BITS:0]     rem_diff;
	logic                fits;

	// Bring down the next dividend bit and try the subtraction.
	assign rem_sh   = {rem_q, quo_q[N_BITS-1]};
	assign rem_diff = rem_sh - {1'b0, divisor};
	assign fits     = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_BITS'(N_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[N_BITS-2:0], fits};
			rem_q <= fits ? rem_diff[D_BITS-1:0] : rem_sh[D_BITS-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

// ===== rtl/core/proper_divisor_sum.sv =====
// Each of the floor(sqrt(n)) + 1 candidates takes a launch, a divider run and a check;
// after the last check the block finishes and then presents the result.
// Throughput: one item at a time; busy stays high from the accepting edge until done.
// The result shows for one cycle with done high; the receiver cannot stall.
// Reset (arst_n low, asynchronous) returns the block to idle and drops done.
`timescale 1ns / 1ps
`default_nettype none
module proper_divisor_sum import pds_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [IN_BITS-1:0]  value,
	output logic                     done,
	output logic [OUT_BITS-1:0]      divisor_sum_out
);

	pds_state_t          state_q, state_nx;
	logic [N_BITS-1:0]   n_q;
	logic [D_BITS-1:0]   d_q;
	logic [OUT_BITS-1:0] acc_q;
	logic [OUT_BITS-1:0] sum_q;
	logic                done_q;

	logic                div_start;
	logic                div_done;
	logic [N_BITS-1:0]   quo;
	logic [D_BITS-1:0]   rem;
	logic                stop;
	logic [OUT_BITS-1:0] add_d;
	logic [OUT_BITS-1:0] add_q;

	pds_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (n_q),
		.divisor   (d_q),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	// Past the square root once the candidate exceeds n / d.
	assign stop  = N_BITS'(d_q) > quo;
	assign add_d = (rem == '0) ? OUT_BITS'(d_q) : '0;
	assign add_q = ((rem == '0) && (quo != N_BITS'(d_q))) ? OUT_BITS'(quo) : '0;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_nx = ST_LAUNCH;
			ST_LAUNCH: state_nx = ST_DIV;
			ST_DIV:    if (div_done) state_nx = ST_CHECK;
			ST_CHECK:  state_nx = stop ? ST_FINISH : ST_LAUNCH;
			ST_FINISH: state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE:   busy = 1'b0;
			ST_LAUNCH: div_start = 1'b1;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= (state_q == ST_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			n_q   <= value[N_BITS-1:0];
			d_q   <= D_BITS'(1);
			acc_q <= '0;
		end else if (state_q == ST_CHECK && !stop) begin
			acc_q <= acc_q + add_d + add_q;
			d_q   <= d_q + 1'b1;
		end
		// Drop n itself from the divisor total.
		if (state_q == ST_FINISH) begin
			sum_q <= acc_q - OUT_BITS'(n_q);
		end
	end

	assign done            = done_q;
	assign divisor_sum_out = sum_q;

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for proper_divisor_sum: directed table, then random items at three idle rates.
// Each result is checked against a typed sum or a trial-division aliquot-sum predictor.
// Depends on pds_pkg and the proper_divisor_sum RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import pds_pkg::*;

	localparam int DIR_ROWS    = 22;
	localparam int RAND_ITEMS  = 78;
	localparam int TAIL_CYCLES = 4 * (N_BITS + 3) + 20;
	localparam int CYCLE_LIMIT = 40_000_000;
	localparam logic [63:0] VALUE_MASK =
		(VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);

	typedef struct packed {
		logic [IN_BITS-1:0]  value;
		logic                typed;
		logic [OUT_BITS-1:0] sum;
	} dir_row_t;

	typedef struct {
		logic [IN_BITS-1:0]  value;
		logic [OUT_BITS-1:0] sum;
	} pending_sum_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [IN_BITS-1:0]  value = '0;
	logic                busy;
	logic                done;
	logic [OUT_BITS-1:0] divisor_sum_out;

	pending_sum_t pending_sums[$];
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int cycles = 0;
	logic [IN_BITS-1:0] largest_value = '0;

	// Typed sums: zero, one, primes 2 and 3, perfect numbers; the rest go to the predictor.
	dir_row_t dir_table [DIR_ROWS] = '{
		'{32'd0,          1'b1, 35'd0},
		'{32'd1,          1'b1, 35'd0},
		'{32'd2,          1'b1, 35'd1},
		'{32'd3,          1'b1, 35'd1},
		'{32'd4,          1'b0, 35'd0},
		'{32'd6,          1'b1, 35'd6},
		'{32'd9,          1'b0, 35'd0},
		'{32'd12,         1'b0, 35'd0},
		'{32'd16,         1'b0, 35'd0},
		'{32'd28,         1'b1, 35'd28},
		'{32'd36,         1'b0, 35'd0},
		'{32'd97,         1'b0, 35'd0},
		'{32'd496,        1'b1, 35'd496},
		'{32'd8128,       1'b1, 35'd8128},
		'{32'd65535,      1'b0, 35'd0},
		'{32'd65536,      1'b0, 35'd0},
		'{32'd65537,      1'b0, 35'd0},
		'{32'h000A_AAAA,  1'b0, 35'd0},
		'{32'h0005_5555,  1'b0, 35'd0},
		'{32'h0010_0000,  1'b0, 35'd0},
		'{32'd33550336,   1'b1, 35'd33550336},
		'{32'hFFFF_FFFF,  1'b0, 35'd0}
	};

	proper_divisor_sum dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.value           (value),
		.done            (done),
		.divisor_sum_out (divisor_sum_out)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Sum of all divisors of v except v, by trial division up to sqrt(v).
	function automatic logic [OUT_BITS-1:0] aliquot_sum(input logic [IN_BITS-1:0] v);
		logic [63:0] n;
		logic [63:0] d;
		logic [63:0] q;
		logic [63:0] total;
		n = 64'(v) & VALUE_MASK;
		total = '0;
		for (d = 64'd1; d <= n / d; d++) begin
			if (n % d == 0) begin
				q = n / d;
				total += d;
				if (q != d)
					total += q;
			end
		end
		total = total - n;
		return total[OUT_BITS-1:0];
	endfunction

	// Hold start until the item is taken, then log its expected sum.
	task automatic send_item(input logic [IN_BITS-1:0] v, input logic typed,
			input logic [OUT_BITS-1:0] sum);
		pending_sum_t entry;
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		entry.value = v;
		entry.sum = typed ? sum : aliquot_sum(v);
		pending_sums.insert(pending_sums.size(), entry);
		items_sent++;
		if (v > largest_value)
			largest_value = v;
	endtask

	task automatic maybe_idle(input int pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [IN_BITS-1:0] random_value;
		int w;
		int k;
		logic [IN_BITS-1:0] v;
		// Keep most values small: latency grows with sqrt(n).
		w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 16);
		if ($urandom_range(0, 4) == 0) begin
			k = $urandom_range(1, 300);
			v = IN_BITS'(k * k);
		end else begin
			v = $urandom & ((IN_BITS'(1) << w) - IN_BITS'(1));
		end
		return v;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d sums outstanding", cycles,
				pending_sums.size());
			$display("FAIL proper_divisor_sum");
			$finish;
		end
	end

	always @(posedge clk) begin
		pending_sum_t head;
		if (done) begin
			results_seen++;
			if (pending_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d with nothing pending", divisor_sum_out);
			end else begin
				head = pending_sums.pop_front();
				if (divisor_sum_out !== head.sum) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch for value 0x%08h: expected %0d, got %0d",
							head.value, head.sum, divisor_sum_out);
				end
			end
		end
	end

	initial begin
		int idle_pct [3];
		int phase;
		int i;
		idle_pct = '{24, 69, 0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_ROWS; i++)
			send_item(dir_table[i].value, dir_table[i].typed, dir_table[i].sum);
		drain();

		for (phase = 0; phase < 3; phase++) begin
			for (i = 0; i < RAND_ITEMS / 3 + (phase == 0 ? RAND_ITEMS % 3 : 0); i++) begin
				maybe_idle(idle_pct[phase]);
				send_item(random_value(), 1'b0, '0);
			end
			// Let the block go idle between idle-rate phases.
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("ran %0d items (%0d from the table, largest 0x%08h), %0d sums checked",
			items_sent, DIR_ROWS, largest_value, results_seen);
		$display("sender idle rates 24%%, 69%% and none; %0d mismatches", mismatches);
		if (mismatches == 0 && pending_sums.size() == 0) begin
			$display("PASS proper_divisor_sum");
		end else begin
			$display("FAIL proper_divisor_sum");
		end
		$finish;
	end

endmodule
`default_nettype wire
